[sv/msp_pkg.sv]
// Shared types and constants for the multi-stack shared pool.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package msp_pkg;

    // Fixed payload widths
    localparam int STACK_NUM_W = 4;
    localparam int DATA_W      = 32;

    // Opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Value returned when nothing was popped
    localparam logic signed [DATA_W-1:0] POP_NONE = '1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // request taken: capture it and read the pool
        logic exec;   // update heads and links, load the result
    } t_cmd;

endpackage

`default_nettype wire

[sv/msp_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on msp_pkg for the payload widths.
`default_nettype none

interface msp_req_if
    import msp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [STACK_NUM_W-1:0]   stack_number;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, opcode, stack_number, push_value, input ready);
    modport sink   (input valid, opcode, stack_number, push_value, output ready);
endinterface

interface msp_rsp_if
    import msp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] pop_value;
    logic                     stack_empty;

    modport source (output valid, status, pop_value, stack_empty, input ready);
    modport sink   (input valid, status, pop_value, stack_empty, output ready);
endinterface

`default_nettype wire

[sv/msp_ctrl.sv]
// Controller for the multi-stack pool: request handshake, two-step
// sequence and result valid. Depends on msp_pkg.
`default_nettype none

module msp_ctrl
    import msp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    // Take a request when idle and the result slot is free or being freed
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_cmd.load  = i_in_valid && o_in_ready;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_out_valid = r_out_valid;

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (o_cmd.load) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A taken request is executed in the next cycle
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("request not executed after load");

    // Execution always presents a result
    a_exec_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("result not valid after execution");

    // A result never appears without an execution step
    a_valid_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.exec))
        else $error("result valid without execution");

    // No load while a request is in execution
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.exec))
        else $error("load during execution");

endmodule

`default_nettype wire

[sv/msp_dpath.sv]
// Datapath for the multi-stack pool: data and link memories, stack heads,
// free list head, fill count and result registers. Depends on msp_pkg.
`default_nettype none

module msp_dpath
    import msp_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int POOL_SLOTS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    input  wire logic                     i_opcode,
    input  wire logic [STACK_NUM_W-1:0]   i_stack_number,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic [1:0]                    o_status,
    output logic signed [DATA_W-1:0]      o_pop_value,
    output logic                          o_stack_empty
);

    localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LINK_W = $clog2(POOL_SLOTS + 1);
    localparam int SN_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SLOTS);

    // Pool memories (data undefined until written)
    logic [DATA_W-1:0] r_slot_data [POOL_SLOTS];
    logic [LINK_W-1:0] r_slot_link [POOL_SLOTS];

    // Control state
    logic [LINK_W-1:0] r_stack_head [NUM_STACKS];
    logic [LINK_W-1:0] r_free_head;
    logic [LINK_W-1:0] r_fill;      // slots below this have had their link written

    // Captured request and pool read data
    logic              r_op;
    logic              r_sn_ok;
    logic [SN_W-1:0]   r_sidx;
    logic [DATA_W-1:0] r_val;
    logic [LINK_W-1:0] r_head;
    logic [SLOT_W-1:0] r_slot;
    logic              r_virgin;
    logic [LINK_W-1:0] r_link_rd;
    logic [DATA_W-1:0] r_data_rd;

    // Result registers
    t_status           r_status;
    logic [DATA_W-1:0] r_pop;
    logic              r_empty;

    // Request decode
    logic              sn_ok;
    logic [SN_W-1:0]   sidx;
    logic [LINK_W-1:0] head_in;
    logic [LINK_W-1:0] rd_link;
    logic [SLOT_W-1:0] rd_slot;

    assign sn_ok   = ({1'b0, i_stack_number} < (STACK_NUM_W + 1)'(NUM_STACKS));
    assign sidx    = sn_ok ? i_stack_number[SN_W-1:0] : '0;
    assign head_in = r_stack_head[sidx];
    assign rd_link = (i_opcode == OP_PUSH) ? r_free_head : head_in;
    assign rd_slot = rd_link[SLOT_W-1:0];

    // Execution step
    logic              free_null;
    logic              head_null;
    logic [LINK_W-1:0] link_eff;
    logic              link_we;
    logic [LINK_W-1:0] link_wd;
    logic              data_we;
    logic              head_we;
    logic [LINK_W-1:0] n_head;
    logic              free_we;
    logic [LINK_W-1:0] n_free_head;
    logic              fill_inc;
    t_status           n_status;
    logic [DATA_W-1:0] n_pop;
    logic              n_empty;

    // An unwritten free slot is taken to link to the slot plus one
    assign link_eff  = r_virgin ? (LINK_W'(r_slot) + LINK_W'(1)) : r_link_rd;
    assign free_null = (r_free_head >= LINK_NULL);
    assign head_null = (r_head >= LINK_NULL);

    always_comb begin
        link_we     = 1'b0;
        link_wd     = r_head;
        data_we     = 1'b0;
        head_we     = 1'b0;
        n_head      = link_eff;
        free_we     = 1'b0;
        n_free_head = link_eff;
        fill_inc    = 1'b0;
        n_status    = ST_OK;
        n_pop       = POP_NONE;
        n_empty     = 1'b0;
        if (!r_sn_ok) begin
            n_status = ST_INVALID;
        end else if (r_op == OP_PUSH) begin
            if (free_null) begin
                n_status = ST_OVERFLOW;
                n_empty  = head_null;
            end else begin
                // free head slot goes on top of the stack
                link_we     = 1'b1;
                link_wd     = r_head;
                data_we     = 1'b1;
                head_we     = 1'b1;
                n_head      = LINK_W'(r_slot);
                free_we     = 1'b1;
                n_free_head = link_eff;
                fill_inc    = r_virgin;
            end
        end else begin
            if (head_null) begin
                n_status = ST_UNDERFLOW;
                n_empty  = 1'b1;
            end else begin
                // top slot goes back to the free list
                link_we     = 1'b1;
                link_wd     = r_free_head;
                head_we     = 1'b1;
                n_head      = link_eff;
                free_we     = 1'b1;
                n_free_head = LINK_W'(r_slot);
                n_pop       = r_data_rd;
                n_empty     = (link_eff >= LINK_NULL);
            end
        end
    end

    // Pool memories: write on execution, registered read on load
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && link_we) begin
            r_slot_link[r_slot] <= link_wd;
        end
        if (i_cmd.exec && data_we) begin
            r_slot_data[r_slot] <= r_val;
        end
        if (i_cmd.load) begin
            r_link_rd <= r_slot_link[rd_slot];
            r_data_rd <= r_slot_data[rd_slot];
        end
    end

    // Heads and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STACKS; k++) begin
                r_stack_head[k] <= LINK_NULL;
            end
            r_free_head <= '0;
            r_fill      <= '0;
        end else if (i_cmd.exec) begin
            if (head_we) begin
                r_stack_head[r_sidx] <= n_head;
            end
            if (free_we) begin
                r_free_head <= n_free_head;
            end
            if (fill_inc) begin
                r_fill <= r_fill + LINK_W'(1);
            end
        end
    end

    // Request capture and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_sn_ok  <= sn_ok;
            r_sidx   <= sidx;
            r_val    <= i_push_value;
            r_head   <= head_in;
            r_slot   <= rd_slot;
            r_virgin <= (i_opcode == OP_PUSH) && (r_free_head == r_fill);
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop    <= n_pop;
            r_empty  <= n_empty;
        end
    end

    assign o_status      = r_status;
    assign o_pop_value   = r_pop;
    assign o_stack_empty = r_empty;

endmodule

`default_nettype wire

[sv/multi_stack_shared_pool.sv]
// Sequence: a taken request is captured together with its pool read, then
// executed in S_EXEC, which registers the result and sets its valid.
// Requests do not overlap: each needs the registered read of the link memory
// and then the write-back of heads and links before the next is taken.
// Reset: synchronous, active low; clears stack heads, free head and fill
// count. No clearing pass; slot data is undefined until pushed.
`default_nettype none

module multi_stack_shared_pool
    import msp_pkg::*;
#(
    parameter int NUM_STACKS = 4,
    parameter int POOL_SLOTS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    msp_req_if.sink    i_req,
    msp_rsp_if.source  o_rsp
);

    t_cmd cmd;

    // Sequencer
    msp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // Pool, heads and result
    msp_dpath #(
        .NUM_STACKS (NUM_STACKS),
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_req.opcode),
        .i_stack_number (i_req.stack_number),
        .i_push_value   (i_req.push_value),
        .o_status       (o_rsp.status),
        .o_pop_value    (o_rsp.pop_value),
        .o_stack_empty  (o_rsp.stack_empty)
    );

endmodule

`default_nettype wire
